// File: design/sorted_point_table_unit_defines.svh
// assertion macros for the sorted point table unit
// used by the control and top modules; no other dependencies
`ifndef SORTED_POINT_TABLE_UNIT_DEFINES_SVH
`define SORTED_POINT_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SPT_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
`define SPT_ASSERT(lbl, prop, msg) `SPT_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)
`else
`define SPT_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define SPT_ASSERT(lbl, prop, msg)
`endif

`endif

// File: design/spt_pkg.sv
// shared types and constants for the sorted point table unit
// no dependencies
package spt_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int COORD_BITS_DEF = 16;

    // fixed port field widths
    localparam int OP_W     = 3;
    localparam int IO_CW    = 16;
    localparam int IDX_W    = 6;
    localparam int POS_W    = 6;
    localparam int CNT_IO_W = 7;
    localparam int STAT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_DELETE = 3'd1,
        OP_SET    = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SHUP,
        S_SHDN,
        S_PLACE,
        S_RDWAIT
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic                updated;
        logic [CNT_IO_W-1:0] entry_count;
        t_status             status;
        logic [IO_CW-1:0]    read_x;
        logic [IO_CW-1:0]    read_y;
    } t_result;

endpackage

// File: design/spt_mem.sv
// point entry memory: one write port, one read port, registered read data
// no dependencies
module spt_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/spt_ctrl.sv
// operation sequencer for the sorted point table: scan, shift and update
// of the entry memory; depends on spt_pkg and the assertion macro header
`include "sorted_point_table_unit_defines.svh"

module spt_ctrl #(
    parameter int DEPTH      = spt_pkg::DEPTH_DEF,
    parameter int COORD_BITS = spt_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [spt_pkg::OP_W-1:0]      i_op,
    input  logic [spt_pkg::IO_CW-1:0]     i_coord_x,
    input  logic [spt_pkg::IO_CW-1:0]     i_coord_y,
    input  logic [spt_pkg::IDX_W-1:0]     i_index,
    output logic                          o_res_valid,
    output spt_pkg::t_result              o_res,
    output logic                          o_mem_we,
    output logic [$clog2(DEPTH)-1:0]      o_mem_waddr,
    output logic [2*COORD_BITS-1:0]       o_mem_wdata,
    output logic                          o_mem_re,
    output logic [$clog2(DEPTH)-1:0]      o_mem_raddr,
    input  logic [2*COORD_BITS-1:0]       i_mem_rdata
);

    import spt_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EW    = 2 * COORD_BITS;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    t_op                   r_op;
    logic [COORD_BITS-1:0] r_cx, r_cy;
    logic [IDX_W-1:0]      r_idx;

    // read sweep: address, end address, direction, more reads to issue
    logic [AW-1:0]         r_ra, n_ra;
    logic [AW-1:0]         r_end, n_end;
    logic                  r_down, n_down;
    logic                  r_more, n_more;
    logic                  r_rv;
    logic [AW-1:0]         r_rd_addr;

    // insert position found during the scan
    logic [AW-1:0]         r_pos, n_pos;
    logic                  r_found, n_found;

    logic [COORD_BITS-1:0] rd_x, rd_y;
    logic [AW-1:0]         idx_a, cnt_m1, pos_now;
    logic                  idx_bad, idx_last, scan_hit, scan_ge, scan_last;
    logic                  tbl_full, ins_end, shift_end;

    assign rd_x      = i_mem_rdata[EW-1 -: COORD_BITS];
    assign rd_y      = i_mem_rdata[COORD_BITS-1:0];
    assign idx_a     = AW'(r_idx);
    assign cnt_m1    = AW'(r_count - CNT_W'(1));
    assign idx_bad   = 32'(r_idx) >= 32'(r_count);
    assign idx_last  = idx_a == cnt_m1;
    assign scan_hit  = r_rv && (rd_x == r_cx);
    assign scan_ge   = rd_x >= r_cx;
    assign scan_last = r_rv && (r_rd_addr == cnt_m1);
    assign tbl_full  = r_count == CNT_W'(DEPTH);
    assign pos_now   = r_found ? r_pos : (scan_ge ? r_rd_addr : AW'(r_count));
    assign ins_end   = pos_now == AW'(r_count);
    assign shift_end = r_rv && (r_rd_addr == r_end);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_EXEC;
            end
            S_EXEC: begin
                unique case (r_op)
                    OP_ADD:    n_state = (r_count == '0) ? S_PLACE : S_SCAN;
                    OP_DELETE: n_state = (idx_bad || idx_last) ? S_IDLE : S_SHDN;
                    OP_READ:   n_state = idx_bad ? S_IDLE : S_RDWAIT;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_SCAN: begin
                priority if (scan_hit) begin
                    n_state = S_IDLE;
                end else if (scan_last) begin
                    priority if (tbl_full) n_state = S_IDLE;
                    else if (ins_end)      n_state = S_PLACE;
                    else                   n_state = S_SHUP;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SHUP: begin
                if (shift_end) n_state = S_PLACE;
            end
            S_SHDN: begin
                if (shift_end) n_state = S_IDLE;
            end
            S_PLACE:  n_state = S_IDLE;
            S_RDWAIT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count     = r_count;
        n_pos       = r_pos;
        n_found     = r_found;
        n_ra        = r_ra;
        n_end       = r_end;
        n_down      = r_down;
        n_more      = r_more;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_rd_addr;
        o_mem_wdata = i_mem_rdata;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_ra;
        o_res_valid = 1'b0;
        o_res       = '{position: '0, updated: 1'b0, entry_count: '0,
                        status: ST_OK, read_x: '0, read_y: '0};

        // sweep read issue shared by scan and both shifts
        if (r_state == S_SCAN || r_state == S_SHUP || r_state == S_SHDN) begin
            o_mem_re = r_more;
            if (r_more) begin
                n_more = r_ra != r_end;
                n_ra   = r_down ? r_ra - AW'(1) : r_ra + AW'(1);
            end
        end

        unique case (r_state)
            S_IDLE: begin
                n_more = 1'b0;
            end
            S_EXEC: begin
                n_more = 1'b0;
                unique case (r_op)
                    OP_ADD: begin
                        n_found = 1'b0;
                        n_pos   = '0;
                        n_ra    = '0;
                        n_end   = cnt_m1;
                        n_down  = 1'b0;
                        n_more  = r_count != '0;
                    end
                    OP_DELETE: begin
                        priority if (idx_bad) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_RANGE;
                        end else if (idx_last) begin
                            n_count        = r_count - CNT_W'(1);
                            o_res_valid    = 1'b1;
                            o_res.position = POS_W'(idx_a);
                        end else begin
                            n_ra   = idx_a + AW'(1);
                            n_end  = cnt_m1;
                            n_down = 1'b0;
                            n_more = 1'b1;
                        end
                    end
                    OP_SET: begin
                        o_res_valid = 1'b1;
                        if (idx_bad) begin
                            o_res.status = ST_RANGE;
                        end else begin
                            o_mem_we       = 1'b1;
                            o_mem_waddr    = idx_a;
                            o_mem_wdata    = {r_cx, r_cy};
                            o_res.position = POS_W'(idx_a);
                        end
                    end
                    OP_READ: begin
                        if (idx_bad) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_RANGE;
                        end else begin
                            o_mem_re    = 1'b1;
                            o_mem_raddr = idx_a;
                        end
                    end
                    OP_CLEAR: begin
                        n_count     = '0;
                        o_res_valid = 1'b1;
                    end
                    default: begin
                        o_res_valid = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_rv) begin
                    if (scan_hit) begin
                        n_more         = 1'b0;
                        o_mem_we       = 1'b1;
                        o_mem_waddr    = r_rd_addr;
                        o_mem_wdata    = {r_cx, r_cy};
                        o_res_valid    = 1'b1;
                        o_res.position = POS_W'(r_rd_addr);
                        o_res.updated  = 1'b1;
                    end else begin
                        if (!r_found && scan_ge) begin
                            n_found = 1'b1;
                            n_pos   = r_rd_addr;
                        end
                        if (scan_last) begin
                            if (tbl_full) begin
                                o_res_valid  = 1'b1;
                                o_res.status = ST_FULL;
                            end else begin
                                n_pos = pos_now;
                                if (!ins_end) begin
                                    // move the tail up, last entry first
                                    n_ra   = cnt_m1;
                                    n_end  = pos_now;
                                    n_down = 1'b1;
                                    n_more = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            S_SHUP: begin
                if (r_rv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_rd_addr + AW'(1);
                end
            end
            S_SHDN: begin
                if (r_rv) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_rd_addr - AW'(1);
                    if (shift_end) begin
                        n_count        = r_count - CNT_W'(1);
                        o_res_valid    = 1'b1;
                        o_res.position = POS_W'(idx_a);
                    end
                end
            end
            S_PLACE: begin
                o_mem_we       = 1'b1;
                o_mem_waddr    = r_pos;
                o_mem_wdata    = {r_cx, r_cy};
                n_count        = r_count + CNT_W'(1);
                o_res_valid    = 1'b1;
                o_res.position = POS_W'(r_pos);
            end
            S_RDWAIT: begin
                o_res_valid    = 1'b1;
                o_res.position = POS_W'(idx_a);
                o_res.read_x   = IO_CW'(rd_x);
                o_res.read_y   = IO_CW'(rd_y);
            end
            default: begin
                n_more = 1'b0;
            end
        endcase

        o_res.entry_count = CNT_IO_W'(n_count);
    end

    assign o_busy = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_more  <= 1'b0;
            r_rv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_more  <= n_more;
            r_rv    <= o_mem_re;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_op  <= t_op'(i_op);
            r_cx  <= COORD_BITS'(i_coord_x);
            r_cy  <= COORD_BITS'(i_coord_y);
            r_idx <= i_index;
        end
        r_ra      <= n_ra;
        r_end     <= n_end;
        r_down    <= n_down;
        r_pos     <= n_pos;
        r_found   <= n_found;
        r_rd_addr <= o_mem_raddr;
    end

    `SPT_ASSERT(a_no_rw_clash, !(o_mem_we && o_mem_re && o_mem_waddr == o_mem_raddr), "read and write hit the same entry")
    `SPT_ASSERT(a_count_range, r_count <= CNT_W'(DEPTH), "entry count beyond depth")
    `SPT_ASSERT(a_count_hold, !o_res_valid |=> $stable(r_count), "entry count moved without a result")
    `SPT_ASSERT(a_idle_after, o_res_valid |=> r_state == S_IDLE, "sequencer not idle after result")

endmodule

// File: design/sorted_point_table_unit.sv
// Sorted point table: up to DEPTH (x, y) points in one single-port-read entry
// memory; an add inserts in x order, but a set may write any x at its index.
// A transaction is taken when start is high and busy is low; busy stays high
// while the operation runs and the result shows on the o_ ports for exactly
// one cycle with o_done, the first cycle with busy low, and must be taken
// then since the receiver cannot stall. Set, clear and unknown ops end in the
// exec state, a read waits for its registered data, a delete shifts the later
// entries down, and an add scans for its x, then updates that entry, reports
// full, or shifts any later entries up and places the point: every step of
// the scan and of the shift moves one entry through the memory's one read port.
// depends on spt_pkg, spt_ctrl, spt_mem and the assertion macro header
`include "sorted_point_table_unit_defines.svh"

module sorted_point_table_unit #(
    parameter int DEPTH      = spt_pkg::DEPTH_DEF,
    parameter int COORD_BITS = spt_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [spt_pkg::OP_W-1:0]     i_op,
    input  logic [spt_pkg::IO_CW-1:0]    i_coord_x,
    input  logic [spt_pkg::IO_CW-1:0]    i_coord_y,
    input  logic [spt_pkg::IDX_W-1:0]    i_index,
    output logic                         o_done,
    output logic [spt_pkg::POS_W-1:0]    o_position,
    output logic                         o_updated,
    output logic [spt_pkg::CNT_IO_W-1:0] o_entry_count,
    output logic [spt_pkg::STAT_W-1:0]   o_status,
    output logic [spt_pkg::IO_CW-1:0]    o_read_x,
    output logic [spt_pkg::IO_CW-1:0]    o_read_y
);

    import spt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int EW = 2 * COORD_BITS;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata, mem_rdata;
    logic          res_valid;
    t_result       res;
    logic          r_done;
    t_result       r_res;

    spt_ctrl #(
        .DEPTH      (DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_op        (i_op),
        .i_coord_x   (i_coord_x),
        .i_coord_y   (i_coord_y),
        .i_index     (i_index),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    spt_mem #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // result register: o_done pulses once per transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_res <= res;
        end
    end

    assign o_done        = r_done;
    assign o_position    = r_res.position;
    assign o_updated     = r_res.updated;
    assign o_entry_count = r_res.entry_count;
    assign o_status      = r_res.status;
    assign o_read_x      = r_res.read_x;
    assign o_read_y      = r_res.read_y;

    `SPT_ASSERT(a_done_single, o_done |=> !o_done, "two results back to back")
    `SPT_ASSERT(a_done_idle, o_done |-> !busy, "result shown while busy")
    `SPT_ASSERT(a_full_count, (o_done && o_status == ST_FULL) |-> o_entry_count == CNT_IO_W'(DEPTH), "full status with table not full")

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// self-checking testbench for sorted_point_table_unit: directed and random transactions,
// results predicted by a tracker class that keeps its own copy of the point table
// depends on spt_pkg and the sorted_point_table_unit design files
module tb;
    import spt_pkg::*;

    localparam int TABLE_DEPTH  = DEPTH_DEF;
    localparam int ITEM_TARGET  = 820;
    localparam int MAX_REPORTS  = 10;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int DRAIN_CYCLES = 20;

    // op codes the block does not decode
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    class point_table_tracker;
        logic [IO_CW-1:0] xs [TABLE_DEPTH];
        logic [IO_CW-1:0] ys [TABLE_DEPTH];
        int               cnt;
        t_result          expected_replies [$];
        int               mismatches;

        function new();
            cnt        = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // apply one accepted transaction to the shadow table and queue its result
        function void note_request(logic [OP_W-1:0] op, logic [IO_CW-1:0] x,
                                   logic [IO_CW-1:0] y, logic [IDX_W-1:0] idx);
            t_result r;
            int      hit;
            int      pos;
            int      i;
            r        = '0;
            r.status = ST_OK;
            case (op)
                OP_ADD: begin
                    hit = -1;
                    for (i = 0; i < cnt; i++)
                        if (hit < 0 && xs[i] == x) hit = i;
                    if (hit >= 0) begin
                        ys[hit]    = y;
                        r.position = POS_W'(hit);
                        r.updated  = 1'b1;
                    end else if (cnt >= TABLE_DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        // insert before the first entry not below x, even if unsorted
                        pos = 0;
                        while (pos < cnt && xs[pos] < x) pos++;
                        for (i = cnt; i > pos; i--) begin
                            xs[i] = xs[i-1];
                            ys[i] = ys[i-1];
                        end
                        xs[pos]    = x;
                        ys[pos]    = y;
                        cnt++;
                        r.position = POS_W'(pos);
                    end
                end
                OP_DELETE, OP_SET, OP_READ: begin
                    if (idx >= cnt) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.position = idx;
                        if (op == OP_DELETE) begin
                            for (i = idx; i < cnt - 1; i++) begin
                                xs[i] = xs[i+1];
                                ys[i] = ys[i+1];
                            end
                            cnt--;
                        end else if (op == OP_SET) begin
                            xs[idx] = x;
                            ys[idx] = y;
                        end else begin
                            r.read_x = xs[idx];
                            r.read_y = ys[idx];
                        end
                    end
                end
                OP_CLEAR: cnt = 0;
                default: ;
            endcase
            r.entry_count = CNT_IO_W'(cnt);
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [POS_W-1:0] position, logic updated,
                                  logic [CNT_IO_W-1:0] entry_count, logic [STAT_W-1:0] status,
                                  logic [IO_CW-1:0] read_x, logic [IO_CW-1:0] read_y);
            t_result want;
            if (expected_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with no transaction pending: pos=%0d cnt=%0d st=%0d",
                             $realtime, position, entry_count, status);
                return;
            end
            want = expected_replies.pop_front();
            if (position !== want.position || updated !== want.updated ||
                entry_count !== want.entry_count || status !== want.status ||
                read_x !== want.read_x || read_y !== want.read_y) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch exp pos=%0d upd=%0d cnt=%0d st=%0d rx=%h ry=%h",
                             $realtime, want.position, want.updated, want.entry_count,
                             want.status, want.read_x, want.read_y);
                    $display("%0t:          got pos=%0d upd=%0d cnt=%0d st=%0d rx=%h ry=%h",
                             $realtime, position, updated, entry_count, status,
                             read_x, read_y);
                end
            end
        endfunction

        function void wrap_up();
            if (expected_replies.size() != 0) begin
                $display("%0d expected results never arrived", expected_replies.size());
                mismatches += expected_replies.size();
            end
        endfunction
    endclass

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                start     = 1'b0;
    logic [OP_W-1:0]     i_op      = '0;
    logic [IO_CW-1:0]    i_coord_x = '0;
    logic [IO_CW-1:0]    i_coord_y = '0;
    logic [IDX_W-1:0]    i_index   = '0;
    logic                busy;
    logic                o_done;
    logic [POS_W-1:0]    o_position;
    logic                o_updated;
    logic [CNT_IO_W-1:0] o_entry_count;
    logic [STAT_W-1:0]   o_status;
    logic [IO_CW-1:0]    o_read_x;
    logic [IO_CW-1:0]    o_read_y;

    point_table_tracker tracker;
    int                 burst_left = 0;
    int                 items_sent = 0;
    int                 cycle_count = 0;

    sorted_point_table_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_index      (i_index),
        .o_done       (o_done),
        .o_position   (o_position),
        .o_updated    (o_updated),
        .o_entry_count(o_entry_count),
        .o_status     (o_status),
        .o_read_x     (o_read_x),
        .o_read_y     (o_read_y)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            tracker.check_reply(o_position, o_updated, o_entry_count, o_status,
                                o_read_x, o_read_y);
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[sorted_point_table_unit] ERROR");
        $finish;
    end

    // drive one transaction and return at the edge that accepts it
    task automatic issue(logic [OP_W-1:0] op, logic [IO_CW-1:0] x, logic [IO_CW-1:0] y,
                         logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(3) == 0) ? $urandom_range(250, 1) : $urandom_range(6, 1);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(120, 50)
                                                  : $urandom_range(15, 1);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_op      <= op;
        i_coord_x <= x;
        i_coord_y <= y;
        i_index   <= idx;
        start     <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        tracker.note_request(op, x, y, idx);
        items_sent++;
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    function automatic logic [IO_CW-1:0] pick_x();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        // reuse a stored x now and then so adds hit the update path
        if (r < 4 && tracker.cnt > 0) return tracker.xs[$urandom_range(tracker.cnt - 1)];
        return IO_CW'($urandom);
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        if (tracker.cnt > 0 && $urandom_range(7) != 0)
            return IDX_W'($urandom_range(tracker.cnt - 1));
        return IDX_W'($urandom);
    endfunction

    task automatic issue_random_op();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            issue(OP_ADD, pick_x(), IO_CW'($urandom), IDX_W'($urandom));
        else if (r < 50)
            issue(OP_DELETE, IO_CW'($urandom), IO_CW'($urandom), pick_index());
        else if (r < 62)
            issue(OP_SET, pick_x(), IO_CW'($urandom), pick_index());
        else if (r < 87)
            issue(OP_READ, IO_CW'($urandom), IO_CW'($urandom), pick_index());
        else if (r < 90)
            issue(OP_CLEAR, IO_CW'($urandom), IO_CW'($urandom), IDX_W'($urandom));
        else if (r < 93)
            issue((r == 90) ? OP_RSVD_5 : (r == 91) ? OP_RSVD_6 : OP_RSVD_7,
                  IO_CW'($urandom), IO_CW'($urandom), IDX_W'($urandom));
        else
            issue(OP_READ, IO_CW'($urandom), IO_CW'($urandom), IDX_W'($urandom));
    endtask

    initial begin : stimulus
        int target;
        int tries;
        tracker = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: every indexed op is out of range; then adds, an update and reads
        issue(OP_READ,   16'h0000, 16'h0000, 6'd0);
        issue(OP_DELETE, 16'hFFFF, 16'hFFFF, 6'd0);
        issue(OP_SET,    16'hFFFF, 16'hFFFF, 6'd63);
        issue(OP_ADD,    16'h8000, 16'hFFFF, 6'd0);
        issue(OP_ADD,    16'h0000, 16'h0000, 6'd63);
        issue(OP_ADD,    16'hFFFF, 16'h1234, 6'd63);
        issue(OP_ADD,    16'h8000, 16'h0000, 6'd0);
        issue(OP_READ,   16'h0000, 16'h0000, 6'd0);
        issue(OP_READ,   16'hFFFF, 16'hFFFF, 6'd2);
        issue(OP_READ,   16'h0000, 16'h0000, 6'd3);
        // break the order, then add into the unsorted table; then deletes, reserved ops and a clear
        issue(OP_SET,    16'hFFFF, 16'h5555, 6'd0);
        issue(OP_ADD,    16'h7000, 16'hAAAA, 6'd0);
        issue(OP_ADD,    16'hFFFF, 16'h0001, 6'd0);
        issue(OP_READ,   16'h0000, 16'h0000, 6'd1);
        issue(OP_DELETE, 16'h0000, 16'h0000, 6'd3);
        issue(OP_DELETE, 16'h0000, 16'h0000, 6'd0);
        issue(OP_DELETE, 16'h0000, 16'h0000, 6'd63);
        issue(OP_RSVD_5, 16'hFFFF, 16'hFFFF, 6'd63);
        issue(OP_RSVD_6, 16'h0000, 16'h0000, 6'd0);
        issue(OP_RSVD_7, 16'hFFFF, 16'h0000, 6'd1);
        issue(OP_CLEAR,  16'hFFFF, 16'hFFFF, 6'd63);
        issue(OP_READ,   16'h0000, 16'h0000, 6'd0);
        drain_replies();

        // sessions: fill to a random level, sometimes past full, then mixed traffic
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(4) == 0)
                issue(OP_CLEAR, IO_CW'($urandom), IO_CW'($urandom), IDX_W'($urandom));
            target = ($urandom_range(2) == 0) ? TABLE_DEPTH + $urandom_range(4, 1)
                                              : $urandom_range(40, 1);
            tries = 0;
            while (tracker.cnt < target && tracker.cnt < TABLE_DEPTH && tries < 200) begin
                issue(OP_ADD, pick_x(), IO_CW'($urandom), IDX_W'($urandom));
                tries++;
            end
            if (target > TABLE_DEPTH) begin
                repeat (target - TABLE_DEPTH)
                    issue(OP_ADD, pick_x(), IO_CW'($urandom), IDX_W'($urandom));
                issue(OP_READ, IO_CW'($urandom), IO_CW'($urandom), 6'd63);
            end
            repeat ($urandom_range(60, 10)) issue_random_op();
            if ($urandom_range(3) == 0) drain_replies();
        end

        start <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.wrap_up();
        if (tracker.mismatches == 0)
            $display("[sorted_point_table_unit] OK");
        else
            $display("[sorted_point_table_unit] ERROR");
        $finish;
    end
endmodule

// File: sorted_point_table_unit.f
+incdir+design
design/spt_pkg.sv
design/spt_mem.sv
design/spt_ctrl.sv
design/sorted_point_table_unit.sv
tb/tb.sv
